FILE: rtl/trc_pkg.sv
// Package for the triangle cell rotate block: coordinate widths, word types,
// turn codes and the anchor struct shared by the datapath modules.
// No dependencies.
package trc_pkg;

   localparam int COORD_BITS = 16;
   localparam int CALC_BITS  = COORD_BITS + 6;
   localparam int TURN_BITS  = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;

   typedef enum logic [TURN_BITS-1:0] {
      TURN_0   = 3'd0,
      TURN_60  = 3'd1,
      TURN_120 = 3'd2,
      TURN_180 = 3'd3,
      TURN_240 = 3'd4,
      TURN_300 = 3'd5,
      TURN_360 = 3'd6,
      TURN_420 = 3'd7
   } turn_type;

   typedef struct packed {
      coord_type                cell_x;
      coord_type                cell_y;
      coord_type                pivot_x;
      coord_type                pivot_y;
      logic [TURN_BITS-1:0]     turn_steps;
   } req_word_type;

   typedef struct packed {
      coord_type rotated_x;
      coord_type rotated_y;
      logic      out_of_range;
   } rsp_word_type;

   // lattice anchor of a cell; down marks an upside-down cell
   typedef struct packed {
      calc_type bu;
      calc_type bv;
      logic     down;
   } anchor_type;

endpackage

FILE: rtl/triangle_cell_rotate_top.sv
// Top level of the triangle cell rotate block: input register, anchor and
// rotate datapath, result register. Depends on trc_pkg, trc_anchor, trc_rotate.
//
// Rotates a triangle-grid cell clockwise by turn_steps * 60 degrees about the
// anchor vertex of a pivot cell, using exact integer lattice math. One word is
// accepted per clock while req_ready is high; a result is formed by one
// combinational pass between the input register and the result register.
// A full result register does not block intake while the input stage is
// free, and both stages advance together when rsp_ready is high. Turns of six
// and seven act as zero and one step. When the rotated cell does not fit the
// coordinate width, out_of_range is set and both coordinates read zero.
module triangle_cell_rotate_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  trc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output trc_pkg::rsp_word_type rsp_word
);

   trc_pkg::req_word_type req_ff;
   trc_pkg::req_word_type req_in;
   logic                  req_valid_ff;
   logic                  req_valid_in;
   trc_pkg::rsp_word_type rsp_ff;
   trc_pkg::rsp_word_type rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_load;
   logic                  req_load;
   trc_pkg::anchor_type   cell_anchor;
   trc_pkg::anchor_type   pivot_anchor;
   trc_pkg::rsp_word_type rsp_calc;

   trc_anchor u_cell_anchor (
      .x      (req_ff.cell_x),
      .y      (req_ff.cell_y),
      .anchor (cell_anchor)
   );

   trc_anchor u_pivot_anchor (
      .x      (req_ff.pivot_x),
      .y      (req_ff.pivot_y),
      .anchor (pivot_anchor)
   );

   trc_rotate u_rotate (
      .cell_anchor (cell_anchor),
      .pivot       (pivot_anchor),
      .turn        (trc_pkg::turn_type'(req_ff.turn_steps)),
      .rsp         (rsp_calc)
   );

   always_comb begin
      rsp_load     = ~rsp_valid_ff | rsp_ready;
      req_load     = ~req_valid_ff | rsp_load;
      req_ready    = req_load;
      req_valid_in = req_load ? req_valid : req_valid_ff;
      req_in       = (req_load && req_valid) ? req_word : req_ff;
      rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;
      rsp_in       = (rsp_load && req_valid_ff) ? rsp_calc : rsp_ff;
      rsp_valid    = rsp_valid_ff;
      rsp_word     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: rtl/trc_anchor.sv
// Maps a logical triangle cell to its lattice anchor vertex and orientation.
// Depends on trc_pkg.
module trc_anchor (
   input  trc_pkg::coord_type  x,
   input  trc_pkg::coord_type  y,
   output trc_pkg::anchor_type anchor
);

   localparam int EXT_BITS = trc_pkg::CALC_BITS - trc_pkg::COORD_BITS;

   logic signed [trc_pkg::COORD_BITS:0] sum;
   logic signed [trc_pkg::COORD_BITS-1:0] half;
   trc_pkg::calc_type x_ext;
   trc_pkg::calc_type y_ext;
   trc_pkg::calc_type half_ext;

   always_comb begin
      x_ext    = {{EXT_BITS{x[trc_pkg::COORD_BITS-1]}}, x};
      y_ext    = {{EXT_BITS{y[trc_pkg::COORD_BITS-1]}}, y};
      sum      = {x[trc_pkg::COORD_BITS-1], x} + {y[trc_pkg::COORD_BITS-1], y};
      // floor(sum/2)
      half     = sum[trc_pkg::COORD_BITS:1];
      half_ext = {{EXT_BITS{half[trc_pkg::COORD_BITS-1]}}, half};
      anchor.down = ~sum[0];
      anchor.bu   = half_ext + trc_pkg::calc_type'(1) - y_ext;
      anchor.bv   = sum[0] ? y_ext : y_ext + trc_pkg::calc_type'(1);
   end

endmodule

FILE: rtl/trc_rotate.sv
// Rotates a cell centroid about the pivot anchor in sixty-degree steps and
// maps the result back to a logical cell with range check. Depends on trc_pkg.
module trc_rotate (
   input  trc_pkg::anchor_type   cell_anchor,
   input  trc_pkg::anchor_type   pivot,
   input  trc_pkg::turn_type     turn,
   output trc_pkg::rsp_word_type rsp
);

   trc_pkg::calc_type da;
   trc_pkg::calc_type db;
   trc_pkg::calc_type dsum;
   trc_pkg::calc_type ra;
   trc_pkg::calc_type rb;
   trc_pkg::calc_type u;
   trc_pkg::calc_type v;
   trc_pkg::calc_type lx;
   trc_pkg::calc_type ly;
   logic              third_pos;
   logic              x_fits;
   logic              y_fits;

   // centroid offset is 3*(da,db) +/- 1; track the whole-unit part only
   always_comb begin
      da   = cell_anchor.bu - pivot.bu;
      db   = cell_anchor.bv - pivot.bv;
      dsum = cell_anchor.down ? da + db - trc_pkg::calc_type'(1)
                              : da + db + trc_pkg::calc_type'(1);
      unique case (turn)
         trc_pkg::TURN_0,
         trc_pkg::TURN_360: begin
            ra = da;
            rb = db;
         end
         trc_pkg::TURN_60,
         trc_pkg::TURN_420: begin
            ra = dsum;
            rb = -da;
         end
         trc_pkg::TURN_120: begin
            ra = db;
            rb = -dsum;
         end
         trc_pkg::TURN_180: begin
            ra = -da;
            rb = -db;
         end
         trc_pkg::TURN_240: begin
            ra = -dsum;
            rb = da;
         end
         trc_pkg::TURN_300: begin
            ra = -db;
            rb = dsum;
         end
         default: begin
            ra = da;
            rb = db;
         end
      endcase
      // fractional part of one third after the turn: right side up
      third_pos = ~cell_anchor.down ^ turn[0];
      u  = pivot.bu + ra;
      v  = pivot.bv + rb;
      ly = third_pos ? v : v - trc_pkg::calc_type'(1);
      lx = (u <<< 1) + v - (third_pos ? trc_pkg::calc_type'(1) : trc_pkg::calc_type'(3));
      x_fits = (&lx[trc_pkg::CALC_BITS-1:trc_pkg::COORD_BITS-1])
             | ~(|lx[trc_pkg::CALC_BITS-1:trc_pkg::COORD_BITS-1]);
      y_fits = (&ly[trc_pkg::CALC_BITS-1:trc_pkg::COORD_BITS-1])
             | ~(|ly[trc_pkg::CALC_BITS-1:trc_pkg::COORD_BITS-1]);
      rsp.out_of_range = ~(x_fits & y_fits);
      if (x_fits && y_fits) begin
         rsp.rotated_x = lx[trc_pkg::COORD_BITS-1:0];
         rsp.rotated_y = ly[trc_pkg::COORD_BITS-1:0];
      end else begin
         rsp.rotated_x = '0;
         rsp.rotated_y = '0;
      end
   end

endmodule
